// File: rtl/minifloat_decode_to_double_assert.svh
// Assertion macros for the minifloat decoder.
`ifndef MINIFLOAT_DECODE_TO_DOUBLE_ASSERT_SVH
`define MINIFLOAT_DECODE_TO_DOUBLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MDD_ASSERT_IMPL(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define MDD_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MDD_ASSERT_IMPL(lbl, clk, rstn, prop)
`define MDD_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// File: rtl/mfd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Minifloat decoder package
// Shared types and constants for the minifloat to double converter.
// ---------------------------------------------------------------------------
package mfd_pkg;
    localparam int FRAC_W = 10;
    localparam int EXP_W  = 5;
    localparam int FBITS_W = 4;
    localparam int EBITS_W = 3;
    localparam int CFG_W  = 4;

    localparam logic [1:0] CLS_NORMAL = 2'd0;
    localparam logic [1:0] CLS_ZERO   = 2'd1;
    localparam logic [1:0] CLS_INF    = 2'd2;
    localparam logic [1:0] CLS_NAN    = 2'd3;

    localparam logic [0:0] REG_FRAC_BITS = 1'b0;
    localparam logic [0:0] REG_EXP_BITS  = 1'b1;

    typedef struct packed {
        logic              sign_bit;
        logic [EXP_W-1:0]  exponent_field;
        logic [FRAC_W-1:0] fraction_field;
        logic [1:0]        value_class;
        logic [63:0]       double_bits;
    } result_t;
endpackage

// File: rtl/minifloat_decode_to_double.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Minifloat to double decoder
// Splits a small float word, classifies it and packs finite values as a binary64 (zero bits for Inf/NaN).
// ---------------------------------------------------------------------------
// Channel   Ports                     Moves
// s_        s_valid/s_ready/s_raw_word  one raw word per request
// m_        m_valid/m_ready/m_*          one decoded result per request
// One request is accepted per cycle while s_ready is high.
// Input register, then conversion logic, then the result register.
// Reset clears both valid flags and restores the format registers.
// A stall on m_ holds the result; the input stage drains into it when free.
// ---------------------------------------------------------------------------
`include "minifloat_decode_to_double_assert.svh"
module minifloat_decode_to_double #(
    parameter int WORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [mfd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   s_raw_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_sign_bit,
    output logic [mfd_pkg::EXP_W-1:0]     m_exponent_field,
    output logic [mfd_pkg::FRAC_W-1:0]    m_fraction_field,
    output logic [1:0]                    m_value_class,
    output logic [63:0]                   m_double_bits
);
    logic [mfd_pkg::FBITS_W-1:0] frac_reg;
    logic [mfd_pkg::EBITS_W-1:0] exp_reg;
    logic [mfd_pkg::FBITS_W-1:0] f_eff;
    logic [mfd_pkg::EBITS_W-1:0] e_eff;
    logic                        in_vld_reg;
    logic [WORD_WIDTH-1:0]       in_word_reg;
    logic                        out_vld_reg;
    mfd_pkg::result_t            out_reg;
    mfd_pkg::result_t            res;
    logic                        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_reg <= 4'd10;
            exp_reg  <= 3'd5;
        end else if (cfg_we) begin
            if (cfg_index == mfd_pkg::REG_FRAC_BITS) frac_reg <= cfg_data;
            else exp_reg <= cfg_data[mfd_pkg::EBITS_W-1:0];
        end
    end

    always_comb begin
        f_eff = (frac_reg < 4'd2) ? 4'd2 : ((frac_reg > 4'd10) ? 4'd10 : frac_reg);
        e_eff = (exp_reg < 3'd3) ? 3'd3 : ((exp_reg > 3'd5) ? 3'd5 : exp_reg);
    end

    assign out_free = !out_vld_reg || m_ready;
    assign s_ready  = !in_vld_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) in_vld_reg <= s_valid;
            if (out_free) out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_word_reg <= s_raw_word[WORD_WIDTH-1:0];
        if (out_free && in_vld_reg) out_reg <= res;
    end

    mfd_convert #(.WORD_WIDTH(WORD_WIDTH)) u_conv (
        .word (in_word_reg),
        .f_eff(f_eff),
        .e_eff(e_eff),
        .res  (res)
    );

    assign m_valid          = out_vld_reg;
    assign m_sign_bit       = out_reg.sign_bit;
    assign m_exponent_field = out_reg.exponent_field;
    assign m_fraction_field = out_reg.fraction_field;
    assign m_value_class    = out_reg.value_class;
    assign m_double_bits    = out_reg.double_bits;

    `MDD_ASSERT_IMPL(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid)
    `MDD_ASSERT_IMPL(a_stall, aclk, aresetn, (in_vld_reg && out_vld_reg && !m_ready) |-> !s_ready)
    `MDD_ASSERT_IMPL(a_special, aclk, aresetn, (m_valid && m_value_class[1]) |-> (m_double_bits == 64'd0))
    `MDD_ASSERT_NORST(a_rst, aclk, !aresetn |=> !m_valid)
endmodule

// File: rtl/mfd_convert.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Minifloat conversion logic
// Field split, classification and double packing of finite values for one word.
// ---------------------------------------------------------------------------
module mfd_convert #(
    parameter int WORD_WIDTH = 16
) (
    input  logic [WORD_WIDTH-1:0]           word,
    input  logic [mfd_pkg::FBITS_W-1:0]     f_eff,
    input  logic [mfd_pkg::EBITS_W-1:0]     e_eff,
    output mfd_pkg::result_t                res
);
    // The word is widened so that format positions above it read as zero.
    logic [31:0]                 wide;
    logic [31:0]                 sh;
    logic [mfd_pkg::FRAC_W-1:0]  m;
    logic [mfd_pkg::EXP_W-1:0]   x;
    logic [mfd_pkg::EXP_W-1:0]   ones;
    logic                        s;
    logic [3:0]                  p;
    logic [10:0]                 bias;
    logic [10:0]                 dexp;
    logic [51:0]                 mant;
    logic [9:0]                  mrem;
    logic [1:0]                  cls;
    logic [63:0]                 bits;

    always_comb begin
        wide = 32'(word);
        m    = mfd_pkg::FRAC_W'(wide & ((32'd1 << f_eff) - 32'd1));
        sh   = wide >> f_eff;
        ones = mfd_pkg::EXP_W'((6'd1 << e_eff) - 6'd1);
        x    = mfd_pkg::EXP_W'(sh) & ones;
        s    = sh[e_eff];
        bias = 11'((6'd1 << (e_eff - 3'd1)) - 6'd1);
        p = 4'd0;
        for (int i = 0; i < mfd_pkg::FRAC_W; i++) begin
            if (m[i]) p = 4'(i);
        end
        mrem = m & ~(10'd1 << p);
        cls  = mfd_pkg::CLS_NORMAL;
        bits = 64'd0;
        dexp = 11'd0;
        mant = 52'd0;
        if (x == ones) begin
            cls = (m == '0) ? mfd_pkg::CLS_INF : mfd_pkg::CLS_NAN;
        end else if (x == '0) begin
            cls = mfd_pkg::CLS_ZERO;
            if (m == '0) begin
                bits = {s, 63'd0};
            end else begin
                dexp = 11'd1024 + 11'(p) - bias - 11'(f_eff);
                mant = 52'(mrem) << (6'd52 - 6'(p));
                bits = {s, dexp, mant};
            end
        end else begin
            dexp = 11'd1023 + 11'(x) - bias;
            mant = 52'(m) << (6'd52 - 6'(f_eff));
            bits = {s, dexp, mant};
        end
        res.sign_bit       = s;
        res.exponent_field = x;
        res.fraction_field = m;
        res.value_class    = cls;
        res.double_bits    = bits;
    end
endmodule
